FILE: design/ifs_pkg.sv
// Package: map table, palette and shared constants for the IFS chaos-game plotter.
`default_nettype none
package ifs_pkg;
   localparam int DefGridRows = 512;
   localparam int DefGridCols = 1024;
   localparam int DefMapSlots = 25;
   localparam int ZoomQ16     = 6554;
   localparam logic [23:0] CountMax = 24'hFFFFFF;

   localparam logic [1:0] CSR_BANK = 2'd0;
   localparam logic [1:0] CSR_ROW  = 2'd1;
   localparam logic [1:0] CSR_COL  = 2'd2;

   typedef struct packed {
      logic signed [17:0] a;
      logic signed [17:0] b;
      logic signed [17:0] c;
      logic signed [17:0] d;
      logic signed [20:0] e;
      logic signed [20:0] f;
   } coef_type;

   function automatic int q16(input int m);
      int r;
      if (m >= 0) r = (m * 65536 + 500) / 1000;
      else        r = -((-m * 65536 + 500) / 1000);
      return r;
   endfunction

   function automatic coef_type mk(input int a, input int b, input int c,
                                   input int d, input int e, input int f);
      coef_type r;
      r.a = 18'(q16(a)); r.b = 18'(q16(b)); r.c = 18'(q16(c));
      r.d = 18'(q16(d)); r.e = 21'(q16(e)); r.f = 21'(q16(f));
      return r;
   endfunction

   function automatic coef_type map_coef(input logic bank, input logic [4:0] idx);
      coef_type r;
      r = mk(0, 0, 0, 0, 0, 0);
      if (!bank) begin
         unique case (idx)
            5'd0:  r = mk(0, -140, 130, 0, -3300, 1000);
            5'd1:  r = mk(0, -140, 45, 0, -2200, 1540);
            5'd2:  r = mk(65, 0, 0, 140, -3000, 2000);
            5'd3:  r = mk(65, 0, 0, 140, -3000, 1000);
            5'd4:  r = mk(34, -135, 126, 36, -1250, 1000);
            5'd5:  r = mk(55, 127, -118, 59, -750, 1600);
            5'd6:  r = mk(39, 0, 0, 140, -1000, 900);
            5'd7:  r = mk(130, 0, 0, 140, 750, 2000);
            5'd8:  r = mk(0, -140, 104, 0, 1250, 1000);
            5'd9:  r = mk(0, -140, 130, 0, 2700, 1000);
            5'd10: r = mk(0, -140, 45, 0, 3800, 1540);
            5'd11: r = mk(65, 0, 0, 140, 3000, 2000);
            5'd12: r = mk(65, 0, 0, 140, 3000, 1000);
            5'd13: r = mk(79, 70, -45, 121, 3000, 700);
            5'd14: r = mk(0, -140, 104, 0, 5000, 800);
            5'd15: r = mk(65, 0, 0, 140, 6750, 2000);
            5'd16: r = mk(65, 0, 0, 140, 6750, 400);
            5'd17: r = mk(0, -140, 130, 0, 6500, 1000);
            5'd18: r = mk(13, 0, 0, 140, 4750, 2000);
            5'd19: r = mk(0, -140, 130, 0, 8500, 1000);
            5'd20: r = mk(64, -99, 64, 99, 9000, 1400);
            5'd21: r = mk(64, 99, -64, 99, 9000, 1000);
            default: r = mk(0, 0, 0, 0, 0, 0);
         endcase
      end else begin
         unique case (idx)
            5'd0:  r = mk(0, -140, 130, 0, -3300, 1000);
            5'd1:  r = mk(0, -140, 45, 0, -2400, 1540);
            5'd2:  r = mk(65, 0, 0, 140, -3000, 2000);
            5'd3:  r = mk(65, 0, 0, 140, -3000, 1000);
            5'd4:  r = mk(65, 0, 0, 140, -3000, 250);
            5'd5:  r = mk(0, -140, 45, 0, -2200, 600);
            5'd6:  r = mk(34, -135, 126, 36, -1250, 1000);
            5'd7:  r = mk(55, 127, -118, 59, -750, 1600);
            5'd8:  r = mk(39, 0, 0, 140, -1000, 900);
            5'd9:  r = mk(130, 0, 0, 140, 750, 2000);
            5'd10: r = mk(0, -140, 104, 0, 1250, 1000);
            5'd11: r = mk(65, 0, 0, 140, 3000, 2000);
            5'd12: r = mk(65, 0, 0, 140, 3000, 400);
            5'd13: r = mk(0, -140, 130, 0, 2750, 1000);
            5'd14: r = mk(39, 0, 0, 140, 3000, 1200);
            5'd15: r = mk(0, -140, 130, 0, 4400, 1000);
            5'd16: r = mk(0, -140, 130, 0, 5600, 1000);
            5'd17: r = mk(22, -132, 61, 48, 5400, 1520);
            5'd18: r = mk(31, 132, -86, 48, 4500, 1760);
            5'd19: r = mk(34, -135, 126, 36, 6750, 1000);
            5'd20: r = mk(55, 127, -118, 59, 7250, 1600);
            5'd21: r = mk(39, 0, 0, 140, 7000, 900);
            5'd22: r = mk(0, -140, 130, 0, 8500, 1000);
            5'd23: r = mk(0, -140, 130, 0, 9400, 1000);
            5'd24: r = mk(27, 135, -100, 36, 8500, 1700);
            default: r = mk(0, 0, 0, 0, 0, 0);
         endcase
      end
      return r;
   endfunction

   function automatic logic [47:0] palette(input logic [1:0] k);
      logic [47:0] r;
      unique case (k)
         2'd0: r = {16'd65535, 16'd52429, 16'd15729};
         2'd1: r = {16'd64225, 16'd33423, 16'd28836};
         2'd2: r = {16'd49807, 16'd21627, 16'd39977};
         2'd3: r = {16'd32113, 16'd21627, 16'd40632};
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

FILE: design/ifs_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module ifs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: design/ifs_chaos_game_plotter_core.sv
// Top level: chaos-game point iteration, cell mapping and hit histogram.
//
// One beat on req_ yields one beat on rsp_. After reset a clearing pass zeroes all
// GRID_ROWS*GRID_COLS (524288) hit counters, one cell per cycle, while req_stall
// is high. A req_ beat is taken in S_IDLE, then the item steps through S_IDX, S_XA,
// S_YB, S_XC, S_YD, S_SATX, S_ZX, S_ZY, S_ADDR, S_READ, S_UPD and S_OUT, which waits
// out any rsp_ stall: one shared 25x18 multiplier forms the map index, the four affine
// products and both zoom products in turn, then the count RAM is read and the
// incremented count is written back as the result is loaded. A new item is taken
// once the previous result has been handed over to the rsp_ register. The grid is
// fixed at 512 rows by 1024 columns.
`default_nettype none
module ifs_chaos_game_plotter_core #(
   parameter int MAP_SLOTS  = ifs_pkg::DefMapSlots,
   localparam int GRID_ROWS = ifs_pkg::DefGridRows,
   localparam int GRID_COLS = ifs_pkg::DefGridCols,
   localparam int RowBits   = $clog2(GRID_ROWS),
   localparam int ColBits   = $clog2(GRID_COLS)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [15:0]        req_rand_u,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [RowBits-1:0]      rsp_cell_row,
   output logic [ColBits-1:0]      rsp_cell_col,
   output logic [15:0]             rsp_red,
   output logic [15:0]             rsp_green,
   output logic [15:0]             rsp_blue,
   output logic [23:0]             rsp_hit_count,
   output logic [23:0]             rsp_max_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [16:0]        csr_data
);
   import ifs_pkg::*;

   localparam int Cells    = GRID_ROWS * GRID_COLS;
   localparam int AddrBits = $clog2(Cells);
   localparam int ScaleSh  = $clog2(GRID_COLS) - $clog2(GRID_ROWS);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_IDX, S_XA, S_YB, S_XC, S_YD, S_SATX,
      S_ZX, S_ZY, S_ADDR, S_READ, S_UPD, S_OUT
   } state_type;

   state_type state_ff;
   logic [AddrBits:0] clr_ff;
   logic bank_ff;
   logic signed [16:0] row_off_ff, col_off_ff;
   logic signed [23:0] px_ff, py_ff;
   logic [47:0] colour_ff;
   logic [23:0] peak_ff;
   logic [15:0] u_ff;
   logic [4:0] idx_ff;
   coef_type co_ff;
   logic signed [47:0] acc_ff;
   logic signed [47:0] prod_ff;
   logic signed [24:0] nx_ff;
   logic [RowBits-1:0] row_ff;
   logic [ColBits-1:0] col_ff;
   logic [AddrBits-1:0] addr_ff;

   // shared multiplier
   logic signed [24:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [42:0] mul_p;
   assign mul_p = mul_a * mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_IDX: begin
            mul_a = 25'($signed({1'b0, u_ff}));
            mul_b = 18'(((bank_ff ? 25 : 22) > MAP_SLOTS) ? MAP_SLOTS : (bank_ff ? 25 : 22));
         end
         S_XA: begin mul_a = 25'(px_ff); mul_b = co_ff.a; end
         S_YB: begin mul_a = 25'(py_ff); mul_b = co_ff.b; end
         S_XC: begin mul_a = 25'(px_ff); mul_b = co_ff.c; end
         S_YD: begin mul_a = 25'(py_ff); mul_b = co_ff.d; end
         S_ZX: begin mul_a = 25'(px_ff); mul_b = 18'(ZoomQ16); end
         S_ZY: begin mul_a = 25'(py_ff); mul_b = 18'(ZoomQ16); end
         default: ;
      endcase
   end

   function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
      if (v > 48'sd8388607) return 24'sh7FFFFF;
      if (v < -48'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   logic wr_en;
   logic out_fire;
   logic [23:0] rd_cnt, wr_cnt, new_cnt;
   logic [AddrBits-1:0] ram_addr;
   logic signed [47:0] aff_sum;
   logic signed [31:0] zq, xs, frac_w;
   logic [4:0] idx_w;
   logic [47:0] pal_w;

   assign out_fire = (state_ff == S_OUT) && (!rsp_valid || !rsp_stall);
   assign new_cnt  = (rd_cnt == CountMax) ? rd_cnt : rd_cnt + 24'd1;
   assign wr_en    = (state_ff == S_CLEAR) || out_fire;
   assign wr_cnt   = (state_ff == S_CLEAR) ? 24'd0 : new_cnt;
   assign ram_addr = (state_ff == S_CLEAR) ? clr_ff[AddrBits-1:0] : addr_ff;
   assign aff_sum  = (acc_ff + 48'(prod_ff) + 48'sd32768) >>> 16;
   assign zq       = 32'(prod_ff >>> 16);
   assign xs       = zq >>> ScaleSh;
   assign idx_w    = (mul_p[20:16] > 5'd24) ? 5'd24 : mul_p[20:16];
   assign pal_w    = palette(idx_ff[1:0]);

   ifs_ram #(.Width(24), .Depth(Cells)) u_count (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (ram_addr),
      .wr_data(wr_cnt),
      .rd_data(rd_cnt)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign frac_w    = '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         bank_ff    <= 1'b0;
         row_off_ff <= 17'sd26214;
         col_off_ff <= -17'sd9830;
         px_ff      <= '0;
         py_ff      <= '0;
         colour_ff  <= '0;
         peak_ff    <= 24'd1;
         rsp_valid  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BANK: bank_ff    <= csr_data[0];
               CSR_ROW:  row_off_ff <= csr_data;
               CSR_COL:  col_off_ff <= csr_data;
               default: ;
            endcase
         end
         if (out_fire) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AddrBits+1)'(Cells - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_valid) begin
               u_ff     <= req_rand_u;
               state_ff <= S_IDX;
            end
            S_IDX: begin
               idx_ff   <= idx_w;
               co_ff    <= map_coef(bank_ff, idx_w);
               state_ff <= S_XA;
            end
            S_XA: begin prod_ff <= 48'(mul_p); acc_ff <= '0; state_ff <= S_YB; end
            S_YB: begin
               acc_ff   <= prod_ff;
               prod_ff  <= 48'(mul_p);
               state_ff <= S_XC;
            end
            S_XC: begin
               nx_ff    <= 25'(aff_sum);
               acc_ff   <= '0;
               prod_ff  <= 48'(mul_p);
               state_ff <= S_YD;
            end
            S_YD: begin
               acc_ff   <= prod_ff;
               prod_ff  <= 48'(mul_p);
               state_ff <= S_SATX;
            end
            S_SATX: begin
               px_ff     <= sat24(48'(nx_ff) + 48'(co_ff.e));
               py_ff     <= sat24(aff_sum + 48'(co_ff.f));
               colour_ff <= {16'((17'(colour_ff[47:32]) + 17'(pal_w[47:32])) >> 1),
                             16'((17'(colour_ff[31:16]) + 17'(pal_w[31:16])) >> 1),
                             16'((17'(colour_ff[15:0])  + 17'(pal_w[15:0])) >> 1)};
               state_ff  <= S_ZX;
            end
            S_ZX: begin prod_ff <= 48'(mul_p); state_ff <= S_ZY; end
            S_ZY: begin
               col_ff   <= ColBits'(16'(xs + 32'sd32768 + 32'(col_off_ff)) >> (16 - ColBits));
               prod_ff  <= 48'(mul_p);
               state_ff <= S_ADDR;
            end
            S_ADDR: begin
               row_ff   <= RowBits'(16'(32'sd65536 - zq + 32'(row_off_ff) + frac_w)
                                    >> (16 - RowBits));
               state_ff <= S_READ;
            end
            S_READ: begin
               addr_ff  <= AddrBits'({row_ff, col_ff});
               state_ff <= S_UPD;
            end
            // count read in flight
            S_UPD: state_ff <= S_OUT;
            S_OUT: if (out_fire) begin
               rsp_cell_row  <= row_ff;
               rsp_cell_col  <= col_ff;
               rsp_red       <= colour_ff[47:32];
               rsp_green     <= colour_ff[31:16];
               rsp_blue      <= colour_ff[15:0];
               rsp_hit_count <= new_cnt;
               rsp_max_count <= (new_cnt > peak_ff) ? new_cnt : peak_ff;
               peak_ff       <= (new_cnt > peak_ff) ? new_cnt : peak_ff;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
